/* sv/seed_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seed_pkg
// shared constants, s-boxes and the g function of the seed cipher
// ----------------------------------------------------------------------------
package seed_pkg;

    localparam int ROUNDS      = 16;
    localparam int RND_W       = $clog2(ROUNDS);
    localparam int KEY_DEPTH   = 16;
    localparam int KEY_AW      = $clog2(KEY_DEPTH);
    localparam int RK_W        = 64;
    localparam logic [31:0] KC_INIT = 32'h9e3779b9;
    localparam logic [7:0]  M0 = 8'hfc;
    localparam logic [7:0]  M1 = 8'hf3;
    localparam logic [7:0]  M2 = 8'hcf;
    localparam logic [7:0]  M3 = 8'h3f;

    localparam logic [0:0] REG_KEY_HIGH = 1'b0;
    localparam logic [0:0] REG_KEY_LOW  = 1'b1;

    localparam logic [7:0] SBOX_ONE [256] = '{
        8'ha9,8'h85,8'hd6,8'hd3,8'h54,8'h1d,8'hac,8'h25,8'h5d,8'h43,8'h18,8'h1e,8'h51,8'hfc,8'hca,8'h63,
        8'h28,8'h44,8'h20,8'h9d,8'he0,8'he2,8'hc8,8'h17,8'ha5,8'h8f,8'h03,8'h7b,8'hbb,8'h13,8'hd2,8'hee,
        8'h70,8'h8c,8'h3f,8'ha8,8'h32,8'hdd,8'hf6,8'h74,8'hec,8'h95,8'h0b,8'h57,8'h5c,8'h5b,8'hbd,8'h01,
        8'h24,8'h1c,8'h73,8'h98,8'h10,8'hcc,8'hf2,8'hd9,8'h2c,8'he7,8'h72,8'h83,8'h9b,8'hd1,8'h86,8'hc9,
        8'h60,8'h50,8'ha3,8'heb,8'h0d,8'hb6,8'h9e,8'h4f,8'hb7,8'h5a,8'hc6,8'h78,8'ha6,8'h12,8'haf,8'hd5,
        8'h61,8'hc3,8'hb4,8'h41,8'h52,8'h7d,8'h8d,8'h08,8'h1f,8'h99,8'h00,8'h19,8'h04,8'h53,8'hf7,8'he1,
        8'hfd,8'h76,8'h2f,8'h27,8'hb0,8'h8b,8'h0e,8'hab,8'ha2,8'h6e,8'h93,8'h4d,8'h69,8'h7c,8'h09,8'h0a,
        8'hbf,8'hef,8'hf3,8'hc5,8'h87,8'h14,8'hfe,8'h64,8'hde,8'h2e,8'h4b,8'h1a,8'h06,8'h21,8'h6b,8'h66,
        8'h02,8'hf5,8'h92,8'h8a,8'h0c,8'hb3,8'h7e,8'hd0,8'h7a,8'h47,8'h96,8'he5,8'h26,8'h80,8'had,8'hdf,
        8'ha1,8'h30,8'h37,8'hae,8'h36,8'h15,8'h22,8'h38,8'hf4,8'ha7,8'h45,8'h4c,8'h81,8'he9,8'h84,8'h97,
        8'h35,8'hcb,8'hce,8'h3c,8'h71,8'h11,8'hc7,8'h89,8'h75,8'hfb,8'hda,8'hf8,8'h94,8'h59,8'h82,8'hc4,
        8'hff,8'h49,8'h39,8'h67,8'hc0,8'hcf,8'hd7,8'hb8,8'h0f,8'h8e,8'h42,8'h23,8'h91,8'h6c,8'hdb,8'ha4,
        8'h34,8'hf1,8'h48,8'hc2,8'h6f,8'h3d,8'h2d,8'h40,8'hbe,8'h3e,8'hbc,8'hc1,8'haa,8'hba,8'h4e,8'h55,
        8'h3b,8'hdc,8'h68,8'h7f,8'h9c,8'hd8,8'h4a,8'h56,8'h77,8'ha0,8'hed,8'h46,8'hb5,8'h2b,8'h65,8'hfa,
        8'he3,8'hb9,8'hb1,8'h9f,8'h5e,8'hf9,8'he6,8'hb2,8'h31,8'hea,8'h6d,8'h5f,8'he4,8'hf0,8'hcd,8'h88,
        8'h16,8'h3a,8'h58,8'hd4,8'h62,8'h29,8'h07,8'h33,8'he8,8'h1b,8'h05,8'h79,8'h90,8'h6a,8'h2a,8'h9a
    };

    localparam logic [7:0] SBOX_TWO [256] = '{
        8'h38,8'he8,8'h2d,8'ha6,8'hcf,8'hde,8'hb3,8'hb8,8'haf,8'h60,8'h55,8'hc7,8'h44,8'h6f,8'h6b,8'h5b,
        8'hc3,8'h62,8'h33,8'hb5,8'h29,8'ha0,8'he2,8'ha7,8'hd3,8'h91,8'h11,8'h06,8'h1c,8'hbc,8'h36,8'h4b,
        8'hef,8'h88,8'h6c,8'ha8,8'h17,8'hc4,8'h16,8'hf4,8'hc2,8'h45,8'he1,8'hd6,8'h3f,8'h3d,8'h8e,8'h98,
        8'h28,8'h4e,8'hf6,8'h3e,8'ha5,8'hf9,8'h0d,8'hdf,8'hd8,8'h2b,8'h66,8'h7a,8'h27,8'h2f,8'hf1,8'h72,
        8'h42,8'hd4,8'h41,8'hc0,8'h73,8'h67,8'hac,8'h8b,8'hf7,8'had,8'h80,8'h1f,8'hca,8'h2c,8'haa,8'h34,
        8'hd2,8'h0b,8'hee,8'he9,8'h5d,8'h94,8'h18,8'hf8,8'h57,8'hae,8'h08,8'hc5,8'h13,8'hcd,8'h86,8'hb9,
        8'hff,8'h7d,8'hc1,8'h31,8'hf5,8'h8a,8'h6a,8'hb1,8'hd1,8'h20,8'hd7,8'h02,8'h22,8'h04,8'h68,8'h71,
        8'h07,8'hdb,8'h9d,8'h99,8'h61,8'hbe,8'he6,8'h59,8'hdd,8'h51,8'h90,8'hdc,8'h9a,8'ha3,8'hab,8'hd0,
        8'h81,8'h0f,8'h47,8'h1a,8'he3,8'hec,8'h8d,8'hbf,8'h96,8'h7b,8'h5c,8'ha2,8'ha1,8'h63,8'h23,8'h4d,
        8'hc8,8'h9e,8'h9c,8'h3a,8'h0c,8'h2e,8'hba,8'h6e,8'h9f,8'h5a,8'hf2,8'h92,8'hf3,8'h49,8'h78,8'hcc,
        8'h15,8'hfb,8'h70,8'h75,8'h7f,8'h35,8'h10,8'h03,8'h64,8'h6d,8'hc6,8'h74,8'hd5,8'hb4,8'hea,8'h09,
        8'h76,8'h19,8'hfe,8'h40,8'h12,8'he0,8'hbd,8'h05,8'hfa,8'h01,8'hf0,8'h2a,8'h5e,8'ha9,8'h56,8'h43,
        8'h85,8'h14,8'h89,8'h9b,8'hb0,8'he5,8'h48,8'h79,8'h97,8'hfc,8'h1e,8'h82,8'h21,8'h8c,8'h1b,8'h5f,
        8'h77,8'h54,8'hb2,8'h1d,8'h25,8'h4f,8'h00,8'h46,8'hed,8'h58,8'h52,8'heb,8'h7e,8'hda,8'hc9,8'hfd,
        8'h30,8'h95,8'h65,8'h3c,8'hb6,8'he4,8'hbb,8'h7c,8'h0e,8'h50,8'h39,8'h26,8'h32,8'h84,8'h69,8'h93,
        8'h37,8'he7,8'h24,8'ha4,8'hcb,8'h53,8'h0a,8'h87,8'hd9,8'h4c,8'h83,8'h8f,8'hce,8'h3b,8'h4a,8'hb7
    };

    function automatic logic [31:0] seed_g(input logic [31:0] x);
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        b0 = SBOX_ONE[x[7:0]];
        b1 = SBOX_TWO[x[15:8]];
        b2 = SBOX_ONE[x[23:16]];
        b3 = SBOX_TWO[x[31:24]];
        seed_g = {(b0 & M3) ^ (b1 & M0) ^ (b2 & M1) ^ (b3 & M2),
                  (b0 & M2) ^ (b1 & M3) ^ (b2 & M0) ^ (b3 & M1),
                  (b0 & M1) ^ (b1 & M2) ^ (b2 & M3) ^ (b3 & M0),
                  (b0 & M0) ^ (b1 & M1) ^ (b2 & M2) ^ (b3 & M3)};
    endfunction

endpackage

/* sv/seed_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seed_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module seed_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wr_data,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        rd_data <= mem[addr];
    end

endmodule

/* sv/seed_block_encrypt_rounds.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seed_block_encrypt_rounds
// seed 128-bit block encryption reporting every round state
// ----------------------------------------------------------------------------
// usage
//   request channel: plain_high/plain_low with in_valid/in_stall. a request is
//   taken when in_valid is high and in_stall low; in_stall stays high while a
//   block is being worked on.
//   result channel: round_number, block_high, block_low, final_round with
//   out_valid/out_stall; 16 results per request in round order, the last one
//   with final_round set and holding the ciphertext.
//   key port: cfg_valid/cfg_ready, cfg_index 0 = key_high, 1 = key_low.
//   written only while idle; other indexes are ignored.
// timing
//   one g unit is shared by everything. a round steps through a key read,
//   three g evaluations, then presenting the result. the first result
//   shows once the key read and the three g evaluations of round 0 are
//   done, and no new request is taken until the last result of a block has
//   been accepted. after a key write the next request first builds the 16
//   round keys, 2 g evaluations each.
// reset
//   rst_n clears the sequencer and marks the round keys stale; key registers
//   reset to zero. when out_stall is high the result is held and the
//   sequencer waits.
// ----------------------------------------------------------------------------
module seed_block_encrypt_rounds
    import seed_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [63:0]          plain_high,
    input  logic [63:0]          plain_low,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [RND_W-1:0]     round_number,
    output logic [63:0]          block_high,
    output logic [63:0]          block_low,
    output logic                 final_round,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [0:0]           cfg_index,
    input  logic [63:0]          cfg_data
);

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_KA   = 8'b0000_0010,
        ST_KB   = 8'b0000_0100,
        ST_RD   = 8'b0000_1000,
        ST_G1   = 8'b0001_0000,
        ST_G2   = 8'b0010_0000,
        ST_G3   = 8'b0100_0000,
        ST_OUT  = 8'b1000_0000
    } state_t;

    state_t             state_reg, state_next;
    logic [63:0]        key_high_reg, key_low_reg;
    logic               keys_current_reg;
    logic [RND_W-1:0]   rnd_reg;
    logic [31:0]        w0_reg, w1_reg, w2_reg, w3_reg, kc_reg;
    logic [31:0]        s0_reg, s1_reg, s2_reg, s3_reg;
    logic [31:0]        ck_reg, t0_reg, t1_reg, ka_reg;
    logic               out_valid_reg, final_reg;
    logic [RND_W-1:0]   out_rnd_reg;
    logic [63:0]        out_hi_reg, out_lo_reg;

    logic [31:0]        g_in, g_out;
    logic               ram_we;
    logic [RND_W-1:0]   ram_addr;
    logic [RK_W-1:0]    ram_rd;
    logic [31:0]        e_val, f_val;
    logic               last_rnd;

    assign g_out    = seed_g(g_in);
    assign last_rnd = (rnd_reg == RND_W'(ROUNDS - 1));
    assign e_val    = t0_reg + g_out;
    assign f_val    = g_out;

    always_comb
    begin
        case (state_reg)
            ST_KA:   g_in = w0_reg + w2_reg - kc_reg;
            ST_KB:   g_in = w1_reg - w3_reg + kc_reg;
            ST_G1:   g_in = s2_reg ^ s3_reg ^ ram_rd[63:32] ^ ram_rd[31:0];
            ST_G2:   g_in = t1_reg + ck_reg;
            ST_G3:   g_in = t1_reg + t0_reg;
            default: g_in = '0;
        endcase
    end

    assign ram_we   = (state_reg == ST_KB);
    assign ram_addr = rnd_reg;

    seed_ram #(.WIDTH(RK_W), .DEPTH(KEY_DEPTH)) u_rk_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .addr    (ram_addr),
        .wr_data ({ka_reg, g_out}),
        .rd_data (ram_rd)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_valid) state_next = keys_current_reg ? ST_RD : ST_KA;
            ST_KA:   state_next = ST_KB;
            ST_KB:   state_next = last_rnd ? ST_RD : ST_KA;
            ST_RD:   state_next = ST_G1;
            ST_G1:   state_next = ST_G2;
            ST_G2:   state_next = ST_G3;
            ST_G3:   state_next = ST_OUT;
            ST_OUT:  if (!out_stall) state_next = last_rnd ? ST_IDLE : ST_RD;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            key_high_reg     <= '0;
            key_low_reg      <= '0;
            keys_current_reg <= 1'b0;
            rnd_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_KEY_HIGH: key_high_reg <= cfg_data;
                    REG_KEY_LOW:  key_low_reg  <= cfg_data;
                    default:      key_low_reg  <= key_low_reg;
                endcase
                keys_current_reg <= 1'b0;
            end
            if (state_reg == ST_IDLE && in_valid)
                rnd_reg <= '0;
            if (state_reg == ST_KB)
            begin
                rnd_reg <= rnd_reg + 1'b1;
                if (last_rnd)
                    keys_current_reg <= 1'b1;
            end
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            if (state_reg == ST_G3)
                out_valid_reg <= 1'b1;
            if (state_reg == ST_OUT && !out_stall)
                rnd_reg <= rnd_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    s0_reg <= plain_high[63:32];
                    s1_reg <= plain_high[31:0];
                    s2_reg <= plain_low[63:32];
                    s3_reg <= plain_low[31:0];
                    w0_reg <= key_high_reg[63:32];
                    w1_reg <= key_high_reg[31:0];
                    w2_reg <= key_low_reg[63:32];
                    w3_reg <= key_low_reg[31:0];
                    kc_reg <= KC_INIT;
                end
            end
            ST_KA: ka_reg <= g_out;
            ST_KB:
            begin
                if (!rnd_reg[0])
                begin
                    w0_reg <= {w1_reg[7:0], w0_reg[31:8]};
                    w1_reg <= {w0_reg[7:0], w1_reg[31:8]};
                end
                else
                begin
                    w2_reg <= {w2_reg[23:0], w3_reg[31:24]};
                    w3_reg <= {w3_reg[23:0], w2_reg[31:24]};
                end
                kc_reg <= {kc_reg[30:0], kc_reg[31]};
            end
            ST_G1:
            begin
                ck_reg <= s2_reg ^ ram_rd[63:32];
                t1_reg <= g_out;
            end
            ST_G2: t0_reg <= g_out;
            ST_G3:
            begin
                out_rnd_reg <= rnd_reg;
                if (!last_rnd)
                begin
                    s0_reg     <= s2_reg;
                    s1_reg     <= s3_reg;
                    s2_reg     <= e_val ^ s0_reg;
                    s3_reg     <= f_val ^ s1_reg;
                    out_hi_reg <= {s2_reg, s3_reg};
                    out_lo_reg <= {e_val ^ s0_reg, f_val ^ s1_reg};
                    final_reg  <= 1'b0;
                end
                else
                begin
                    s0_reg     <= s0_reg ^ e_val;
                    s1_reg     <= s1_reg ^ f_val;
                    out_hi_reg <= {s0_reg ^ e_val, s1_reg ^ f_val};
                    out_lo_reg <= {s2_reg, s3_reg};
                    final_reg  <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign round_number = out_rnd_reg;
    assign block_high   = out_hi_reg;
    assign block_low    = out_lo_reg;
    assign final_round  = final_reg;
    assign out_valid    = out_valid_reg;

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg));

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid
            && $stable({round_number, block_high, block_low, final_round}));

    a_final_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> final_round == (round_number == RND_W'(ROUNDS - 1)));

    a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> !out_valid);

endmodule
